@@ hw/rtl/shlex_pkg.sv @@
package shlex_pkg;

    localparam int KIND_W  = 4;
    localparam int START_W = 10;
    localparam int LEN_W   = 11;
    localparam int INDEX_W = 7;

    localparam logic [KIND_W-1:0] K_END     = 4'd0;
    localparam logic [KIND_W-1:0] K_ARG     = 4'd1;
    localparam logic [KIND_W-1:0] K_ROUT    = 4'd2;
    localparam logic [KIND_W-1:0] K_APPEND  = 4'd3;
    localparam logic [KIND_W-1:0] K_RIN     = 4'd4;
    localparam logic [KIND_W-1:0] K_HEREDOC = 4'd5;
    localparam logic [KIND_W-1:0] K_PIPE    = 4'd6;
    localparam logic [KIND_W-1:0] K_OR      = 4'd7;
    localparam logic [KIND_W-1:0] K_AND     = 4'd8;
    localparam logic [KIND_W-1:0] K_SEP     = 4'd9;

    typedef struct packed {
        logic                  last;
        logic                  truncated;
        logic [INDEX_W-1:0]    token_index;
        logic [LEN_W-1:0]      token_length;
        logic [START_W-1:0]    start_offset;
        logic [KIND_W-1:0]     kind;
    } result_t;

endpackage

@@ hw/rtl/shlex_rq.sv @@
module shlex_rq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_count,
    input  shlex_pkg::result_t  push_data0,
    input  shlex_pkg::result_t  push_data1,
    output logic                room2,
    output logic                out_valid,
    input  logic                out_ready,
    output shlex_pkg::result_t  out_data
);

    shlex_pkg::result_t mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign room2     = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_count} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_data0;
        end
        if (push_count == 2'd2)
        begin
            mem[wr_ptr_reg + 2'd1] <= push_data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/shell_command_line_lexer_core.sv @@
// An accepted byte is registered, and its results then go into the result queue,
// which drives the master side. Throughput: one byte per cycle while the queue has
// room for two results; a byte with two tokens puts both in the single-read queue.
// Reset (rst_n low, async): line state, token count and result queue clear;
// pending results are dropped.
module shell_command_line_lexer_core #(
    parameter int MAX_TOKENS = 64,
    parameter int MAX_LINE   = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] kind, [13:4] start_offset,
                                   // [24:14] token_length, [31:25] token_index,
                                   // [32] truncated, [39:33] zero
    output logic        m_tlast    // last
);

    localparam int PW = $clog2(MAX_LINE + 1);
    localparam int SW = $clog2(MAX_LINE);
    localparam int CW = $clog2(MAX_TOKENS + 1);

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_GT   = 3'd1;
    localparam logic [2:0] OP_LT   = 3'd2;
    localparam logic [2:0] OP_BAR  = 3'd3;
    localparam logic [2:0] OP_AMP  = 3'd4;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_eol_reg;
    logic          room2;
    logic          proc;

    logic [PW-1:0] pos_reg, pos_next;
    logic          arg_open_reg, arg_open_next;
    logic [SW-1:0] arg_start_reg, arg_start_next;
    logic [2:0]    pend_reg, pend_next;
    logic [SW-1:0] op_start_reg, op_start_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;

    logic          is_space, is_semi;
    logic [2:0]    op;
    logic          consumed;
    logic [SW-1:0] p_s;

    logic                          cand_v     [4];
    logic                          cand_end   [4];
    logic [shlex_pkg::KIND_W-1:0]  cand_kind  [4];
    logic [shlex_pkg::START_W-1:0] cand_start [4];
    logic [shlex_pkg::LEN_W-1:0]   cand_len   [4];

    shlex_pkg::result_t res0, res1, slot;
    logic [1:0]         n_res;
    shlex_pkg::result_t q_out;

    assign proc     = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eol_reg  <= s_tlast;
        end
    end

    always_comb
    begin
        is_space = (in_byte_reg == 8'h20) || (in_byte_reg == 8'h09) || (in_byte_reg == 8'h0A);
        is_semi  = (in_byte_reg == 8'h3B);
        unique case (in_byte_reg)
            8'h3E:   op = OP_GT;
            8'h3C:   op = OP_LT;
            8'h7C:   op = OP_BAR;
            8'h26:   op = OP_AMP;
            default: op = OP_NONE;
        endcase
    end

    assign p_s = SW'(pos_reg);

    // Candidate tokens in emit order: pending operator, closed argument,
    // separator, terminator.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cand_v[i]     = 1'b0;
            cand_end[i]   = 1'b0;
            cand_kind[i]  = shlex_pkg::K_END;
            cand_start[i] = '0;
            cand_len[i]   = '0;
        end
        consumed       = 1'b0;
        pos_next       = pos_reg;
        arg_open_next  = arg_open_reg;
        arg_start_next = arg_start_reg;
        pend_next      = pend_reg;
        op_start_next  = op_start_reg;

        cand_start[0] = shlex_pkg::START_W'(op_start_reg);
        cand_start[1] = shlex_pkg::START_W'(arg_start_reg);
        cand_len[1]   = shlex_pkg::LEN_W'(pos_reg - PW'(arg_start_reg));
        cand_kind[1]  = shlex_pkg::K_ARG;
        cand_start[2] = shlex_pkg::START_W'(p_s);
        cand_len[2]   = shlex_pkg::LEN_W'(1);
        cand_kind[2]  = shlex_pkg::K_SEP;
        cand_end[3]   = 1'b1;

        unique case (pend_reg)
            OP_GT:   cand_kind[0] = shlex_pkg::K_ROUT;
            OP_LT:   cand_kind[0] = shlex_pkg::K_RIN;
            OP_BAR:  cand_kind[0] = shlex_pkg::K_PIPE;
            default: cand_kind[0] = shlex_pkg::K_AND;
        endcase
        cand_len[0] = shlex_pkg::LEN_W'(1);

        if (in_eol_reg)
        begin
            cand_v[1]      = arg_open_reg;
            cand_v[0]      = (pend_reg != OP_NONE);
            cand_v[3]      = 1'b1;
            pos_next       = '0;
            arg_open_next  = 1'b0;
            arg_start_next = '0;
            pend_next      = OP_NONE;
            op_start_next  = '0;
        end
        else if (pos_reg < PW'(MAX_LINE))
        begin
            if (pend_reg == OP_AMP)
            begin
                cand_v[0] = 1'b1;
                if (!is_space)
                begin
                    cand_len[0] = shlex_pkg::LEN_W'(2);
                    consumed    = 1'b1;
                end
                pend_next = OP_NONE;
            end
            else if (pend_reg != OP_NONE)
            begin
                cand_v[0] = 1'b1;
                if (op == pend_reg)
                begin
                    cand_len[0] = shlex_pkg::LEN_W'(2);
                    unique case (pend_reg)
                        OP_GT:   cand_kind[0] = shlex_pkg::K_APPEND;
                        OP_LT:   cand_kind[0] = shlex_pkg::K_HEREDOC;
                        default: cand_kind[0] = shlex_pkg::K_OR;
                    endcase
                    consumed = 1'b1;
                end
                pend_next = OP_NONE;
            end
            if (!consumed)
            begin
                if (is_space || is_semi || (op != OP_NONE))
                begin
                    cand_v[1]     = arg_open_reg;
                    arg_open_next = 1'b0;
                    cand_v[2]     = is_semi;
                    if (op != OP_NONE)
                    begin
                        pend_next     = op;
                        op_start_next = p_s;
                    end
                end
                else if (!arg_open_reg)
                begin
                    arg_open_next  = 1'b1;
                    arg_start_next = p_s;
                end
            end
            pos_next = pos_reg + PW'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        n_res      = 2'd0;
        res0       = '0;
        res1       = '0;
        for (int i = 0; i < 4; i++)
        begin
            slot              = '0;
            slot.kind         = cand_kind[i];
            slot.start_offset = cand_start[i];
            slot.token_length = cand_len[i];
            slot.token_index  = shlex_pkg::INDEX_W'(count_next);
            slot.truncated    = ovf_next;
            if (cand_v[i])
            begin
                if (cand_end[i] || (count_next < CW'(MAX_TOKENS)))
                begin
                    if (n_res == 2'd0)
                    begin
                        res0 = slot;
                    end
                    else
                    begin
                        res1 = slot;
                    end
                    n_res = n_res + 2'd1;
                    if (!cand_end[i])
                    begin
                        count_next = count_next + CW'(1);
                    end
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end
        if (n_res == 2'd1)
        begin
            res0.last = 1'b1;
        end
        if (n_res == 2'd2)
        begin
            res1.last = 1'b1;
        end
        if (in_eol_reg)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            arg_open_reg  <= 1'b0;
            arg_start_reg <= '0;
            pend_reg      <= OP_NONE;
            op_start_reg  <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
        end
        else if (proc)
        begin
            pos_reg       <= pos_next;
            arg_open_reg  <= arg_open_next;
            arg_start_reg <= arg_start_next;
            pend_reg      <= pend_next;
            op_start_reg  <= op_start_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
        end
    end

    shlex_rq u_rq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (proc ? n_res : 2'd0),
        .push_data0 (res0),
        .push_data1 (res1),
        .room2      (room2),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (q_out)
    );

    assign m_tdata = {7'd0, q_out.truncated, q_out.token_index, q_out.token_length,
                      q_out.start_offset, q_out.kind};
    assign m_tlast = q_out.last;

endmodule
